[design/ddd_pkg.sv]
// Package for the drawdown event detector.
// Holds widths, the control state type and the event record shared by the tracker and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ddd_pkg;

    localparam int INDEX_BITS          = 16;
    localparam int VALUE_BITS          = 32;
    localparam int DEPTH_FRACTION_BITS = 16;
    localparam int SIGNED_BITS         = INDEX_BITS + 1;
    localparam int DIV_CNT_BITS        = $clog2(DEPTH_FRACTION_BITS);

    // Packed output word: ten fields, padded to whole bytes.
    localparam int OUT_RAW_BITS  = 4 * INDEX_BITS + 3 * SIGNED_BITS + 2 * VALUE_BITS
                                   + DEPTH_FRACTION_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int IN_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    // One closed drawdown event, apart from its depth.
    typedef struct packed {
        logic [INDEX_BITS-1:0]  event_number;
        logic [INDEX_BITS-1:0]  peak_position;
        logic [INDEX_BITS-1:0]  trough_position;
        logic [SIGNED_BITS-1:0] recovery_position;
        logic [VALUE_BITS-1:0]  peak_level;
        logic [VALUE_BITS-1:0]  trough_level;
        logic [INDEX_BITS-1:0]  decline_length;
        logic [SIGNED_BITS-1:0] recovery_length;
        logic [SIGNED_BITS-1:0] total_length;
    } t_event;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

[design/ddd_tracker.sv]
// Peak and trough tracker of the drawdown event detector.
// Keeps the running peak, the open event and the sample index; uses ddd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddd_tracker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic [ddd_pkg::VALUE_BITS-1:0] i_value,
    input  wire logic                           i_first,
    input  wire logic                           i_last,
    output logic                                o_emit,
    output ddd_pkg::t_event                     o_event
);

    localparam logic [ddd_pkg::INDEX_BITS-1:0] IDX_MAX = '1;

    logic [ddd_pkg::VALUE_BITS-1:0] r_peak, n_peak;
    logic [ddd_pkg::INDEX_BITS-1:0] r_peak_pos, n_peak_pos;
    logic                           r_below, n_below;
    logic [ddd_pkg::INDEX_BITS-1:0] r_open_peak_pos, n_open_peak_pos;
    logic [ddd_pkg::VALUE_BITS-1:0] r_open_peak_lvl, n_open_peak_lvl;
    logic [ddd_pkg::INDEX_BITS-1:0] r_trough_pos, n_trough_pos;
    logic [ddd_pkg::VALUE_BITS-1:0] r_trough_lvl, n_trough_lvl;
    logic [ddd_pkg::INDEX_BITS-1:0] r_sample_pos, n_sample_pos;
    logic [ddd_pkg::INDEX_BITS-1:0] r_evt_cnt, n_evt_cnt;

    logic [ddd_pkg::INDEX_BITS-1:0] idx;
    logic                           emit_rec;
    logic                           emit_unrec;

    // Next tracking state for one accepted sample.
    always_comb begin
        n_peak          = r_peak;
        n_peak_pos      = r_peak_pos;
        n_below         = r_below;
        n_open_peak_pos = r_open_peak_pos;
        n_open_peak_lvl = r_open_peak_lvl;
        n_trough_pos    = r_trough_pos;
        n_trough_lvl    = r_trough_lvl;
        n_sample_pos    = r_sample_pos;
        n_evt_cnt       = r_evt_cnt;
        idx             = i_first ? '0 : r_sample_pos;
        emit_rec        = 1'b0;
        emit_unrec      = 1'b0;
        if (i_accept) begin
            if (i_first) begin
                n_peak     = i_value;
                n_peak_pos = '0;
                n_below    = 1'b0;
                n_evt_cnt  = '0;
            end else if (i_value >= r_peak) begin
                emit_rec   = r_below;
                n_peak     = i_value;
                n_peak_pos = idx;
            end else if (!r_below) begin
                n_below         = 1'b1;
                n_open_peak_pos = r_peak_pos;
                n_open_peak_lvl = r_peak;
                n_trough_pos    = idx;
                n_trough_lvl    = i_value;
            end else if (i_value < r_trough_lvl) begin
                n_trough_pos = idx;
                n_trough_lvl = i_value;
            end
            n_sample_pos = (idx < IDX_MAX) ? idx + 1'b1 : IDX_MAX;
            emit_unrec   = i_last && n_below && !emit_rec;
            if (emit_rec || emit_unrec) begin
                n_below = 1'b0;
                if (r_evt_cnt < IDX_MAX) begin
                    n_evt_cnt = r_evt_cnt + 1'b1;
                end
            end
        end
    end

    // Event record as seen after this sample.
    always_comb begin
        o_emit                  = emit_rec || emit_unrec;
        o_event.event_number    = r_evt_cnt;
        o_event.peak_position   = n_open_peak_pos;
        o_event.trough_position = n_trough_pos;
        o_event.peak_level      = n_open_peak_lvl;
        o_event.trough_level    = n_trough_lvl;
        o_event.decline_length  = n_trough_pos - n_open_peak_pos;
        if (emit_rec) begin
            o_event.recovery_position = {1'b0, idx};
            o_event.recovery_length   = {1'b0, idx - n_trough_pos};
            o_event.total_length      = {1'b0, idx - n_open_peak_pos};
        end else begin
            o_event.recovery_position = '1;
            o_event.recovery_length   = '1;
            o_event.total_length      = '1;
        end
    end

    // Tracking registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak          <= '0;
            r_peak_pos      <= '0;
            r_below         <= 1'b0;
            r_open_peak_pos <= '0;
            r_open_peak_lvl <= '0;
            r_trough_pos    <= '0;
            r_trough_lvl    <= '0;
            r_sample_pos    <= '0;
            r_evt_cnt       <= '0;
        end else begin
            r_peak          <= n_peak;
            r_peak_pos      <= n_peak_pos;
            r_below         <= n_below;
            r_open_peak_pos <= n_open_peak_pos;
            r_open_peak_lvl <= n_open_peak_lvl;
            r_trough_pos    <= n_trough_pos;
            r_trough_lvl    <= n_trough_lvl;
            r_sample_pos    <= n_sample_pos;
            r_evt_cnt       <= n_evt_cnt;
        end
    end

endmodule

`default_nettype wire

[design/ddd_divider.sv]
// Bit-serial restoring fraction divider of the drawdown event detector.
// Shifts one quotient bit into a shift register per cycle; uses ddd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddd_divider (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic [ddd_pkg::VALUE_BITS-1:0]          i_num,
    input  wire logic [ddd_pkg::VALUE_BITS-1:0]          i_den,
    output ddd_pkg::t_div_status                         o_status,
    output logic [ddd_pkg::DEPTH_FRACTION_BITS-1:0]      o_quotient
);

    localparam logic [ddd_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
        ddd_pkg::DIV_CNT_BITS'(ddd_pkg::DEPTH_FRACTION_BITS - 1);

    logic [ddd_pkg::VALUE_BITS-1:0]          r_rem, n_rem;
    logic [ddd_pkg::VALUE_BITS-1:0]          r_den;
    logic [ddd_pkg::DEPTH_FRACTION_BITS-1:0] r_quo, n_quo;
    logic [ddd_pkg::DIV_CNT_BITS-1:0]        r_cnt;
    logic                                    r_busy;
    logic                                    r_done;

    logic [ddd_pkg::VALUE_BITS:0] rem_sh;
    logic [ddd_pkg::VALUE_BITS:0] diff;
    logic                         ge;

    // One restoring step: shift the remainder, subtract the divisor if it fits.
    always_comb begin
        rem_sh = {r_rem, 1'b0};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? diff[ddd_pkg::VALUE_BITS-1:0] : rem_sh[ddd_pkg::VALUE_BITS-1:0];
        n_quo  = {r_quo[ddd_pkg::DEPTH_FRACTION_BITS-2:0], ge};
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Step counter and status flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

`default_nettype wire

[design/drawdown_event_detector_top.sv]
// Top level of the drawdown event detector.
// Instantiates ddd_tracker and ddd_divider; uses ddd_pkg.
//
// Usage:
//   Sample words enter on the s_axis channel: tdata holds the value, tuser marks
//   the first sample of a series and tlast the last one. Drawdown events leave
//   on the m_axis channel, one word per event: tdata holds the event fields and
//   tuser flags an event deeper than every earlier one of the series.
//   After a sample that closes no event, the next one may follow at once. A
//   sample that closes an event starts the bit-serial depth divider, which
//   yields one quotient bit per cycle and holds tready low; tready returns high
//   in the cycle after the event word is loaded into the output register.
//   The output register holds a finished event while the receiver stalls; the
//   block keeps accepting samples that close no event, and a sample that closes
//   a second event waits after its division until the register is free.
//   Reset clears all tracking state and drops the output valid; the first
//   sample after reset starts a series even without a first mark.
`timescale 1ns / 1ps
`default_nettype none

module drawdown_event_detector_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Slave tdata fields, low bit up: sample_value.
    input  wire logic [ddd_pkg::IN_DATA_BITS-1:0]   i_s_axis_tdata,
    // Slave tuser fields: first_sample.
    input  wire logic                               i_s_axis_tuser,
    input  wire logic                               i_s_axis_tlast,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // Master tdata fields, low bit up: event_number, peak_position,
    // trough_position, recovery_position, peak_level, trough_level,
    // depth_fraction, decline_length, recovery_length, total_length.
    output logic [ddd_pkg::OUT_DATA_BITS-1:0]       o_m_axis_tdata,
    // Master tuser fields: deepest_so_far.
    output logic                                    o_m_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready
);

    ddd_pkg::t_state      r_state, n_state;
    ddd_pkg::t_event      r_evt;
    ddd_pkg::t_event      trk_event;
    ddd_pkg::t_div_status div_status;

    logic [ddd_pkg::DEPTH_FRACTION_BITS-1:0] quotient;
    logic [ddd_pkg::DEPTH_FRACTION_BITS-1:0] r_worst;
    logic [ddd_pkg::OUT_DATA_BITS-1:0]       r_out_data;
    logic                                    r_out_deep;
    logic                                    r_out_valid;

    logic in_accept;
    logic trk_emit;
    logic div_start;
    logic load_out;
    logic out_free;
    logic deeper;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign deeper    = quotient > r_worst;

    ddd_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_value (i_s_axis_tdata[ddd_pkg::VALUE_BITS-1:0]),
        .i_first (i_s_axis_tuser),
        .i_last  (i_s_axis_tlast),
        .o_emit  (trk_emit),
        .o_event (trk_event)
    );

    ddd_divider u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num     (trk_event.peak_level - trk_event.trough_level),
        .i_den     (trk_event.peak_level),
        .o_status  (div_status),
        .o_quotient(quotient)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddd_pkg::S_IDLE: begin
                if (in_accept && trk_emit) begin
                    n_state = ddd_pkg::S_DIV;
                end
            end
            ddd_pkg::S_DIV: begin
                if (div_status.done) begin
                    n_state = ddd_pkg::S_HOLD;
                end
            end
            ddd_pkg::S_HOLD: begin
                if (out_free) begin
                    n_state = ddd_pkg::S_IDLE;
                end
            end
            default: n_state = ddd_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        div_start       = 1'b0;
        load_out        = 1'b0;
        unique case (r_state)
            ddd_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                div_start       = i_s_axis_tvalid && trk_emit;
            end
            ddd_pkg::S_DIV: begin
            end
            ddd_pkg::S_HOLD: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Event record captured while its depth is divided.
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_evt <= trk_event;
        end
    end

    // Deepest depth of the series, cleared by a first mark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worst <= '0;
        end else if (in_accept && i_s_axis_tuser) begin
            r_worst <= '0;
        end else if (load_out && deeper) begin
            r_worst <= quotient;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= ddd_pkg::OUT_DATA_BITS'({r_evt.total_length,
                                                   r_evt.recovery_length,
                                                   r_evt.decline_length,
                                                   quotient,
                                                   r_evt.trough_level,
                                                   r_evt.peak_level,
                                                   r_evt.recovery_position,
                                                   r_evt.trough_position,
                                                   r_evt.peak_position,
                                                   r_evt.event_number});
            r_out_deep <= deeper;
        end
    end

    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_deep;
    assign o_m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire

[design/ddd_checker.sv]
// Port-level checker for the drawdown event detector, bound to the top level.
// Watches only the top-level ports; uses ddd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddd_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_s_axis_tready,
    input wire logic [ddd_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    input wire logic                               o_m_axis_tuser,
    input wire logic                               o_m_axis_tvalid,
    input wire logic                               i_m_axis_tready
);

    localparam int RP_LO = 3 * ddd_pkg::INDEX_BITS;
    localparam int RL_LO = RP_LO + ddd_pkg::SIGNED_BITS + 2 * ddd_pkg::VALUE_BITS
                           + ddd_pkg::DEPTH_FRACTION_BITS + ddd_pkg::INDEX_BITS;
    localparam int TL_LO = RL_LO + ddd_pkg::SIGNED_BITS;
    localparam int DF_LO = RP_LO + ddd_pkg::SIGNED_BITS + 2 * ddd_pkg::VALUE_BITS;

    logic rec_none, rl_none, tl_none;
    logic [ddd_pkg::DEPTH_FRACTION_BITS-1:0] depth;

    assign rec_none = &o_m_axis_tdata[RP_LO +: ddd_pkg::SIGNED_BITS];
    assign rl_none  = &o_m_axis_tdata[RL_LO +: ddd_pkg::SIGNED_BITS];
    assign tl_none  = &o_m_axis_tdata[TL_LO +: ddd_pkg::SIGNED_BITS];
    assign depth    = o_m_axis_tdata[DF_LO +: ddd_pkg::DEPTH_FRACTION_BITS];

    // A stalled event word stays valid.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("event word dropped while stalled");

    // A stalled event word keeps its payload.
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("event payload changed while stalled");

    // Unrecovered marks agree across the three signed fields.
    a_unrec_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (rec_none == rl_none) && (rec_none == tl_none))
        else $error("recovery fields disagree on unrecovered event");

    // A deepest-so-far event has nonzero depth.
    a_deep_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> depth != '0)
        else $error("deepest flag on a zero-depth event");

    // A new event word appears only after the input side was held off for the divide.
    a_event_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("event word without a divide phase");

endmodule

bind drawdown_event_detector_top ddd_checker u_ddd_checker (.*);

`default_nettype wire
